FILE: rtl/sgr_style_register_update_top_assert.svh
// Assertion macros for the SGR style register checks.
`ifndef SGR_STYLE_REGISTER_UPDATE_TOP_ASSERT_SVH
`define SGR_STYLE_REGISTER_UPDATE_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SGR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the cycle after an antecedent.
`define SGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sgr_pkg.sv
// Types and constants shared by the SGR style register modules.
`default_nettype none

package sgr_pkg;

    localparam int ATTR_W = 10;

    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_TABLE   = 2'd1;
    localparam logic [1:0] KIND_RGB     = 2'd2;

    localparam logic [ATTR_W-1:0] ATTR_UNDER      = 10'h008;
    localparam logic [ATTR_W-1:0] ATTR_UNDER2     = 10'h200;
    localparam logic [ATTR_W-1:0] ATTR_BOLD_FAINT = 10'h003;
    localparam logic [ATTR_W-1:0] ATTR_SLANT      = 10'h004;
    localparam logic [ATTR_W-1:0] ATTR_BLINKS     = 10'h030;
    localparam logic [ATTR_W-1:0] ATTR_INVERSE    = 10'h040;
    localparam logic [ATTR_W-1:0] ATTR_HIDDEN     = 10'h080;

    localparam logic [15:0] CODE_RESET       = 16'd0;
    localparam logic [15:0] CODE_SET_LAST    = 16'd9;
    localparam logic [15:0] CODE_DBL_UNDER   = 16'd21;
    localparam logic [15:0] CODE_CLR_FIRST   = 16'd22;
    localparam logic [15:0] CODE_CLR_LAST    = 16'd28;
    localparam logic [15:0] CODE_FG_FIRST    = 16'd30;
    localparam logic [15:0] CODE_BG_FIRST    = 16'd40;
    localparam logic [15:0] CODE_BG_LAST     = 16'd49;
    localparam logic [15:0] CODE_BR_FG_FIRST = 16'd90;
    localparam logic [15:0] CODE_BR_FG_LAST  = 16'd97;
    localparam logic [15:0] CODE_BR_BG_FIRST = 16'd100;
    localparam logic [15:0] CODE_BR_BG_LAST  = 16'd107;

    localparam logic [7:0] CODE_CLR_BOLD    = 8'd22;
    localparam logic [7:0] CODE_CLR_ITALIC  = 8'd23;
    localparam logic [7:0] CODE_CLR_UNDER   = 8'd24;
    localparam logic [7:0] CODE_CLR_BLINK   = 8'd25;
    localparam logic [7:0] CODE_CLR_REVERSE = 8'd27;
    localparam logic [7:0] CODE_CLR_CONCEAL = 8'd28;

    localparam logic [3:0] DIGIT_EXTENDED = 4'd8;
    localparam logic [3:0] DIGIT_DEFAULT  = 4'd9;

    localparam logic [7:0] SUB_TABLE = 8'd5;
    localparam logic [7:0] SUB_RGB   = 8'd2;

    // bright codes map to table entries 8-15
    localparam logic [7:0] BR_FG_OFFSET = 8'd82;
    localparam logic [7:0] BR_BG_OFFSET = 8'd92;

    typedef struct packed {
        logic [15:0] code;
        logic [7:0]  sub_kind;
        logic [7:0]  sub_a;
        logic [7:0]  sub_b;
        logic [7:0]  sub_c;
        logic        final_param;
    } in_item_t;

    typedef struct packed {
        logic [ATTR_W-1:0] attr_bits;
        logic [1:0]        fg_kind;
        logic [7:0]        fg_index;
        logic [7:0]        fg_red;
        logic [7:0]        fg_green;
        logic [7:0]        fg_blue;
        logic [1:0]        bg_kind;
        logic [7:0]        bg_index;
        logic [7:0]        bg_red;
        logic [7:0]        bg_green;
        logic [7:0]        bg_blue;
        logic              sequence_done;
    } out_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        colour_t           fg;
        colour_t           bg;
    } style_t;

    localparam colour_t COLOUR_DEFAULT = '{kind: KIND_DEFAULT, index: 8'd0,
                                           red: 8'd0, green: 8'd0, blue: 8'd0};

    localparam style_t STYLE_RESET = '{attr: '0, fg: COLOUR_DEFAULT, bg: COLOUR_DEFAULT};

    function automatic colour_t colour_table(input logic [7:0] idx);
        colour_t c;
        c       = COLOUR_DEFAULT;
        c.kind  = KIND_TABLE;
        c.index = idx;
        return c;
    endfunction

    function automatic colour_t colour_rgb(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        colour_t c;
        c       = COLOUR_DEFAULT;
        c.kind  = KIND_RGB;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sgr_in_stage.sv
// Input register stage for SGR parameter items.
`default_nettype none

module sgr_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             param_valid,
    output logic                  param_stall,
    input  wire sgr_pkg::in_item_t param,
    input  wire logic             take,
    output logic                  hold_valid,
    output sgr_pkg::in_item_t     hold_item
);
    import sgr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign param_stall = valid_reg && !take;
    assign accept      = param_valid && !param_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= param;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

`default_nettype wire

FILE: rtl/sgr_update.sv
// Next-style decode for one SGR parameter.
`default_nettype none

module sgr_update (
    input  wire sgr_pkg::style_t   cur,
    input  wire sgr_pkg::in_item_t item,
    output sgr_pkg::style_t        nxt
);
    import sgr_pkg::*;

    logic [ATTR_W-1:0] clr_mask;
    logic              is_bg;
    logic [7:0]        digit8;
    logic [3:0]        digit;
    colour_t           col_old;
    colour_t           col_new;

    always_comb
    begin
        case (item.code[7:0])
            CODE_CLR_BOLD:    clr_mask = ATTR_BOLD_FAINT;
            CODE_CLR_ITALIC:  clr_mask = ATTR_SLANT;
            CODE_CLR_UNDER:   clr_mask = ATTR_UNDER | ATTR_UNDER2;
            CODE_CLR_BLINK:   clr_mask = ATTR_BLINKS;
            CODE_CLR_REVERSE: clr_mask = ATTR_INVERSE;
            CODE_CLR_CONCEAL: clr_mask = ATTR_HIDDEN;
            default:          clr_mask = '0;
        endcase
    end

    // colour codes 30-49: tens digit picks the layer, units digit the action
    always_comb
    begin
        is_bg   = item.code >= CODE_BG_FIRST;
        digit8  = item.code[7:0] - (is_bg ? CODE_BG_FIRST[7:0] : CODE_FG_FIRST[7:0]);
        digit   = digit8[3:0];
        col_old = is_bg ? cur.bg : cur.fg;
        case (digit)
            DIGIT_EXTENDED:
            begin
                if (item.sub_kind == SUB_TABLE)
                begin
                    col_new = colour_table(item.sub_a);
                end
                else if (item.sub_kind == SUB_RGB)
                begin
                    col_new = colour_rgb(item.sub_a, item.sub_b, item.sub_c);
                end
                else
                begin
                    col_new = col_old;
                end
            end
            DIGIT_DEFAULT: col_new = COLOUR_DEFAULT;
            default:       col_new = colour_table({4'd0, digit});
        endcase
    end

    always_comb
    begin
        nxt = cur;
        if (item.code == CODE_RESET)
        begin
            nxt = STYLE_RESET;
        end
        else if (item.code <= CODE_SET_LAST)
        begin
            nxt.attr = cur.attr | (ATTR_W'(1) << (item.code[3:0] - 4'd1));
        end
        else if (item.code == CODE_DBL_UNDER)
        begin
            nxt.attr = cur.attr | ATTR_UNDER2;
        end
        else if (item.code >= CODE_CLR_FIRST && item.code <= CODE_CLR_LAST)
        begin
            nxt.attr = cur.attr & ~clr_mask;
        end
        else if (item.code >= CODE_FG_FIRST && item.code <= CODE_BG_LAST)
        begin
            if (is_bg)
            begin
                nxt.bg = col_new;
            end
            else
            begin
                nxt.fg = col_new;
            end
        end
        else if (item.code >= CODE_BR_FG_FIRST && item.code <= CODE_BR_FG_LAST)
        begin
            nxt.fg = colour_table(item.code[7:0] - BR_FG_OFFSET);
        end
        else if (item.code >= CODE_BR_BG_FIRST && item.code <= CODE_BR_BG_LAST)
        begin
            nxt.bg = colour_table(item.code[7:0] - BR_BG_OFFSET);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sgr_style_register_update_top.sv
// Top level of the SGR style register: input stage, decode, style and result registers.
//
// channel | role   | handshake                 | payload
// param   | input  | param_valid / param_stall | sgr_pkg::in_item_t
// style   | output | style_valid / style_stall | sgr_pkg::out_item_t
//
// One item per cycle while not stalled; path: input register, then result register.
// The style register and the result register load together from the decode.
// Reset returns the style to no attributes and default colours.
// A stalled result holds; the input register still takes one more item.
`default_nettype none

module sgr_style_register_update_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              param_valid,
    output logic                   param_stall,
    input  wire sgr_pkg::in_item_t param,
    output logic                   style_valid,
    input  wire logic              style_stall,
    output sgr_pkg::out_item_t     style
);
    import sgr_pkg::*;

    logic      hold_valid;
    in_item_t  hold_item;
    logic      take;
    style_t    style_reg;
    style_t    style_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_reg;

    assign take = hold_valid && (!out_valid_reg || !style_stall);

    sgr_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .param_valid (param_valid),
        .param_stall (param_stall),
        .param       (param),
        .take        (take),
        .hold_valid  (hold_valid),
        .hold_item   (hold_item)
    );

    sgr_update u_upd (
        .cur  (style_reg),
        .item (hold_item),
        .nxt  (style_next)
    );

    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (style_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            style_reg     <= STYLE_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                style_reg <= style_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg.attr_bits     <= style_next.attr;
            out_reg.fg_kind       <= style_next.fg.kind;
            out_reg.fg_index      <= style_next.fg.index;
            out_reg.fg_red        <= style_next.fg.red;
            out_reg.fg_green      <= style_next.fg.green;
            out_reg.fg_blue       <= style_next.fg.blue;
            out_reg.bg_kind       <= style_next.bg.kind;
            out_reg.bg_index      <= style_next.bg.index;
            out_reg.bg_red        <= style_next.bg.red;
            out_reg.bg_green      <= style_next.bg.green;
            out_reg.bg_blue       <= style_next.bg.blue;
            out_reg.sequence_done <= hold_item.final_param;
        end
    end

    assign style_valid = out_valid_reg;
    assign style       = out_reg;

endmodule

`default_nettype wire

FILE: rtl/sgr_chk.sv
// Port-level checker for the SGR style register, bound to the top level.
`default_nettype none
`include "sgr_style_register_update_top_assert.svh"

module sgr_chk (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               param_valid,
    input wire logic               param_stall,
    input wire sgr_pkg::in_item_t  param,
    input wire logic               style_valid,
    input wire logic               style_stall,
    input wire sgr_pkg::out_item_t style
);
    import sgr_pkg::*;

    logic unused_in;
    assign unused_in = param_valid ^ param_stall ^ (^param);

    `SGR_ASSERT_ALWAYS(a_kind_legal, !style_valid || (style.fg_kind <= KIND_RGB && style.bg_kind <= KIND_RGB), "colour kind out of range")
    `SGR_ASSERT_ALWAYS(a_index_clean, !style_valid || ((style.fg_kind == KIND_TABLE || style.fg_index == 8'd0) && (style.bg_kind == KIND_TABLE || style.bg_index == 8'd0)), "table index set on non-table colour")
    `SGR_ASSERT_ALWAYS(a_rgb_clean, !style_valid || ((style.fg_kind == KIND_RGB || (style.fg_red == 8'd0 && style.fg_green == 8'd0 && style.fg_blue == 8'd0)) && (style.bg_kind == KIND_RGB || (style.bg_red == 8'd0 && style.bg_green == 8'd0 && style.bg_blue == 8'd0))), "rgb set on non-rgb colour")
    `SGR_ASSERT_NEXT(a_out_hold, style_valid && style_stall, style_valid && $stable(style), "stalled result changed")

endmodule

bind sgr_style_register_update_top sgr_chk u_sgr_chk (.*);

`default_nettype wire
